/* sv/fms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fms_pkg
// Types, constants and the twiddle table of the FFT magnitude spectrum block.
// ----------------------------------------------------------------------------
package fms_pkg;

	localparam int MAX_LOG2 = 10;
	localparam int MAX_PTS  = 1 << MAX_LOG2;
	localparam int TW_HALF  = MAX_PTS / 2;
	localparam int SMP_W    = 16;
	localparam int TW_W     = 18;
	localparam int WK_W     = 28;
	localparam int MAG_W    = 26;
	localparam int SQ_W     = 2 * WK_W;
	localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef struct packed {
		logic                    action;
		logic signed [SMP_W-1:0] sample;
		logic [MAX_LOG2-1:0]     bin_index;
	} item_t;

	typedef struct packed {
		logic [MAG_W-1:0] magnitude;
		logic             spectrum_valid;
	} result_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} q_if_t;

	typedef struct packed {
		logic signed [WK_W-1:0] re;
		logic signed [WK_W-1:0] im;
	} work_t;

	// cos and sin in Q31 of an angle of at most pi/4, returned as {cos, sin}
	function automatic logic [127:0] octant(input longint unsigned m);
		longint unsigned x;
		longint unsigned t;
		longint          cs;
		longint          sn;
		x  = ((TWO_PI_Q60 / 64'(MAX_PTS)) * m + (64'd1 << 28)) >> 29;
		t  = x;
		cs = 64'sd1 <<< 31;
		sn = longint'(x);
		for (int n = 2; n <= 15; n++) begin
			t = ((t * x) >> 31) / 64'(n);
			case (n % 4)
				0: cs = cs + longint'(t);
				1: sn = sn + longint'(t);
				2: cs = cs - longint'(t);
				default: sn = sn - longint'(t);
			endcase
		end
		return {cs, sn};
	endfunction

	function automatic logic [TW_W-1:0] to_tw(input longint q);
		longint v;
		longint hi;
		hi = (64'sd1 <<< (TW_W - 1)) - 1;
		v  = (q + (64'sd1 <<< (31 - TW_W))) >>> (32 - TW_W);
		if (v > hi) v = hi;
		if (v < -hi - 1) v = -hi - 1;
		return v[TW_W-1:0];
	endfunction

	// entry j holds {re, im} of the twiddle for angle 2*pi*j/MAX_PTS
	function automatic logic [TW_HALF*2*TW_W-1:0] build_tw();
		logic [TW_HALF*2*TW_W-1:0] acc;
		logic [127:0]              cs;
		longint unsigned           m;
		longint                    c;
		longint                    s;
		logic                      neg;
		acc = '0;
		for (int j = 0; j < TW_HALF; j++) begin
			m   = longint'(j);
			neg = 1'b0;
			if (j > MAX_PTS / 4) begin
				m   = longint'(TW_HALF - j);
				neg = 1'b1;
			end
			if (m <= longint'(MAX_PTS / 8)) begin
				cs = octant(m);
				c  = cs[127:64];
				s  = cs[63:0];
			end else begin
				cs = octant(longint'(MAX_PTS / 4) - m);
				s  = cs[127:64];
				c  = cs[63:0];
			end
			if (neg) c = -c;
			acc[j*2*TW_W +: 2*TW_W] = {to_tw(c), to_tw(-s)};
		end
		return acc;
	endfunction

	localparam logic [TW_HALF*2*TW_W-1:0] TW_ROM = build_tw();

endpackage

/* sv/fms_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fms_front
// Input side: accepts items into a two-entry queue toward the engine.
// ----------------------------------------------------------------------------
module fms_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  fms_pkg::item_t   item,
	output fms_pkg::q_if_t   q,
	input  logic             take
);

	fms_pkg::item_t slot_q [2];
	logic [1:0]     cnt_q;
	logic           wp_q;
	logic           rp_q;
	logic           push;
	logic           pop;

	assign item_stall = (cnt_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign pop        = take && (cnt_q != 2'd0);
	assign q.valid    = (cnt_q != 2'd0);
	assign q.item     = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

/* sv/fms_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fms_back
// Engine: sample load, butterfly passes, magnitude roots and bin reads.
// ----------------------------------------------------------------------------
module fms_back (
	input  logic             clk,
	input  logic             arst_n,
	input  fms_pkg::q_if_t   q,
	output logic             take,
	input  logic             cfg_valid,
	input  logic [3:0]       cfg_data,
	output logic             result_valid,
	input  logic             result_stall,
	output fms_pkg::result_t result
);

	localparam int LW = fms_pkg::MAX_LOG2;
	localparam int PW = fms_pkg::TW_W;
	localparam int WW = fms_pkg::WK_W;
	localparam int SW = fms_pkg::SQ_W;
	localparam int MW = fms_pkg::MAG_W;
	localparam logic signed [WW+PW:0] RND = (WW + PW + 1)'(1) <<< (PW - 2);
	localparam logic [SW-1:0] SQ_TOP = SW'(1) << (SW - 2);
	localparam logic [SW-1:0] MAG_MAX = SW'((64'd1 << MW) - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_BF_RD, S_BF_MUL, S_BF_ADD, S_BF_WA, S_BF_WB,
		S_MG_RD, S_MG_SQ, S_MG_SUM, S_MG_IT, S_MG_WR
	} state_t;

	state_t              state_q;
	logic [3:0]          size_q;
	logic [LW:0]         lcnt_q;
	logic                done_q;
	logic [LW-2:0]       c_q;
	logic [3:0]          st_q;
	logic [LW-1:0]       m_q;
	logic [4:0]          it_q;

	fms_pkg::work_t      work_mem [fms_pkg::MAX_PTS];
	logic [MW-1:0]       mag_mem  [fms_pkg::MAX_PTS];
	fms_pkg::work_t      rda_q;
	fms_pkg::work_t      rdb_q;
	logic [MW-1:0]       mag_rd_q;
	logic [2*PW-1:0]     tw_q;

	fms_pkg::work_t      a_q;
	logic signed [WW+PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
	fms_pkg::work_t      na_q;
	fms_pkg::work_t      nb_q;
	logic [SW-1:0]       sq_re_q, sq_im_q;
	logic [SW-1:0]       v_q, r_q, bit_q;

	logic [3:0]          bits;
	logic [LW:0]         npts;
	logic [LW-1:0]       rev;
	logic [LW-1:0]       ld_addr;
	logic [LW-1:0]       cc;
	logic [LW-1:0]       half;
	logic [LW-1:0]       kk;
	logic [LW-1:0]       bf_a;
	logic [LW-1:0]       bf_b;
	logic [LW-2:0]       tw_addr;
	logic                bf_last;
	logic                we;
	logic [LW-1:0]       waddr;
	fms_pkg::work_t      wdata;
	logic [LW-1:0]       rd_addr;
	logic signed [WW+PW:0] sr, si;
	logic signed [WW+1:0]  pr, pi;
	logic [SW-1:0]       trial;
	logic                is_read;
	logic                bin_ok;

	function automatic logic signed [WW-1:0] sat(input logic signed [WW+2:0] v);
		logic signed [WW+2:0] hi;
		hi = (WW + 3)'((64'sd1 <<< (WW - 1)) - 1);
		if (v > hi) return hi[WW-1:0];
		if (v < -hi - 1) return WW'(-hi - 1);
		return v[WW-1:0];
	endfunction

	always_comb begin
		bits = size_q;
		if (size_q == 4'd0) bits = 4'd1;
		if (size_q > 4'(LW)) bits = 4'(LW);
		npts = (LW + 1)'(1) << bits;
		for (int i = 0; i < LW; i++) rev[i] = lcnt_q[LW-1-i];
		ld_addr = rev >> (4'(LW) - bits);
		cc      = {1'b0, c_q};
		half    = LW'(1) << (st_q - 4'd1);
		kk      = cc & (half - LW'(1));
		bf_a    = ((cc >> (st_q - 4'd1)) << st_q) | kk;
		bf_b    = bf_a | half;
		tw_addr = (LW - 1)'(kk << (4'(LW) - st_q));
		bf_last = (cc == LW'((npts >> 1) - (LW + 1)'(1)));
		is_read = (q.item.action == fms_pkg::ACT_READ);
		bin_ok  = done_q && ({1'b0, q.item.bin_index} < npts);
		take    = (state_q == S_IDLE) && q.valid && (!is_read || !result_valid);
		rd_addr = (state_q == S_MG_RD) ? m_q : bf_a;
		sr = (WW + PW + 1)'(p_rr_q) - (WW + PW + 1)'(p_ii_q) + RND;
		si = (WW + PW + 1)'(p_ri_q) + (WW + PW + 1)'(p_ir_q) + RND;
		pr = (WW + 2)'(sr >>> (PW - 1));
		pi = (WW + 2)'(si >>> (PW - 1));
		trial = r_q + bit_q;
		we    = 1'b0;
		waddr = bf_a;
		wdata = na_q;
		case (state_q)
			S_IDLE: begin
				we       = take && !is_read;
				waddr    = ld_addr;
				wdata.re = WW'(q.item.sample);
				wdata.im = '0;
			end
			S_BF_WA: we = 1'b1;
			S_BF_WB: begin
				we    = 1'b1;
				waddr = bf_b;
				wdata = nb_q;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) work_mem[waddr] <= wdata;
		rda_q <= work_mem[rd_addr];
		rdb_q <= work_mem[bf_b];
		tw_q  <= fms_pkg::TW_ROM[tw_addr*2*PW +: 2*PW];
		if (state_q == S_MG_WR) mag_mem[m_q] <= (r_q > MAG_MAX) ? MW'(MAG_MAX) : MW'(r_q);
		mag_rd_q <= mag_mem[q.item.bin_index];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_BF_MUL: begin
				a_q    <= rda_q;
				p_rr_q <= $signed(tw_q[2*PW-1:PW]) * rdb_q.re;
				p_ii_q <= $signed(tw_q[PW-1:0]) * rdb_q.im;
				p_ri_q <= $signed(tw_q[2*PW-1:PW]) * rdb_q.im;
				p_ir_q <= $signed(tw_q[PW-1:0]) * rdb_q.re;
			end
			S_BF_ADD: begin
				na_q.re <= sat((WW + 3)'(a_q.re) + (WW + 3)'(pr));
				na_q.im <= sat((WW + 3)'(a_q.im) + (WW + 3)'(pi));
				nb_q.re <= sat((WW + 3)'(a_q.re) - (WW + 3)'(pr));
				nb_q.im <= sat((WW + 3)'(a_q.im) - (WW + 3)'(pi));
			end
			S_MG_SQ: begin
				sq_re_q <= SW'(rda_q.re * rda_q.re);
				sq_im_q <= SW'(rda_q.im * rda_q.im);
			end
			S_MG_SUM: begin
				v_q   <= sq_re_q + sq_im_q;
				r_q   <= '0;
				bit_q <= SQ_TOP;
			end
			S_MG_IT: begin
				if (v_q >= trial) begin
					v_q <= v_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			size_q       <= 4'(LW);
			lcnt_q       <= '0;
			done_q       <= 1'b0;
			c_q          <= '0;
			st_q         <= 4'd1;
			m_q          <= '0;
			it_q         <= '0;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			if (result_valid && !result_stall) result_valid <= 1'b0;
			if (cfg_valid) begin
				size_q <= cfg_data;
				lcnt_q <= '0;
				done_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take && is_read) begin
						if (bin_ok) begin
							state_q <= S_RD;
						end else begin
							result       <= '0;
							result_valid <= 1'b1;
						end
					end else if (take) begin
						if (lcnt_q + (LW + 1)'(1) >= npts) begin
							lcnt_q  <= '0;
							c_q     <= '0;
							st_q    <= 4'd1;
							state_q <= S_BF_RD;
						end else begin
							lcnt_q <= lcnt_q + (LW + 1)'(1);
						end
					end
				end
				S_RD: begin
					result.magnitude      <= mag_rd_q;
					result.spectrum_valid <= 1'b1;
					result_valid          <= 1'b1;
					state_q               <= S_IDLE;
				end
				S_BF_RD:  state_q <= S_BF_MUL;
				S_BF_MUL: state_q <= S_BF_ADD;
				S_BF_ADD: state_q <= S_BF_WA;
				S_BF_WA:  state_q <= S_BF_WB;
				S_BF_WB: begin
					if (!bf_last) begin
						c_q     <= c_q + (LW - 1)'(1);
						state_q <= S_BF_RD;
					end else if (st_q == bits) begin
						m_q     <= '0;
						state_q <= S_MG_RD;
					end else begin
						c_q     <= '0;
						st_q    <= st_q + 4'd1;
						state_q <= S_BF_RD;
					end
				end
				S_MG_RD:  state_q <= S_MG_SQ;
				S_MG_SQ:  state_q <= S_MG_SUM;
				S_MG_SUM: begin
					it_q    <= '0;
					state_q <= S_MG_IT;
				end
				S_MG_IT: begin
					it_q <= it_q + 5'd1;
					if (it_q == 5'(SW / 2 - 1)) state_q <= S_MG_WR;
				end
				S_MG_WR: begin
					if ({1'b0, m_q} == npts - (LW + 1)'(1)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						m_q     <= m_q + LW'(1);
						state_q <= S_MG_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* sv/fft_magnitude_spectrum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fft_magnitude_spectrum
// Radix-2 FFT of a real frame with a stored integer magnitude spectrum.
// ----------------------------------------------------------------------------
// The engine takes a load sample whenever it is idle. A read of a stored bin
// passes S_RD before its result is registered; other reads register zero directly.
// The sample that ends a frame runs the transform: (N/2)*log2(N) butterflies
// on one butterfly unit (S_BF_RD to S_BF_WB), then a square and bit-serial
// root per bin (S_MG_RD to S_MG_WR), while the engine takes no item. Reset
// clears control state; work and magnitude stores hold garbage until written.
module fft_magnitude_spectrum (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  fms_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output fms_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [3:0]       cfg_data
);

	fms_pkg::q_if_t q;
	logic           take;

	assign cfg_ready = 1'b1;

	fms_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q          (q),
		.take       (take)
	);

	fms_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q            (q),
		.take         (take),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.spectrum_valid |-> result.magnitude == '0)
		else $error("bin without spectrum carries a magnitude");

	a_full_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> q.valid)
		else $error("queue full with nothing offered to the engine");

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> q.valid)
		else $error("engine took from an empty queue");

endmodule

/* bench/tb_fft_magnitude_spectrum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fft_magnitude_spectrum
// Self-checking bench for the FFT magnitude spectrum block.
// A directed table covers reset reads, length clamping, out-of-range bins and
// full-scale samples; random frames at many lengths follow. Typed reads expect
// zero; every other read is checked against a bit-exact software FFT in the bench.
// ----------------------------------------------------------------------------
module tb_fft_magnitude_spectrum;

	import fms_pkg::*;

	localparam int TOTAL_ITEMS = 1750;
	localparam logic [63:0] TWO_PI = 64'h6487ED5110B4611A;
	localparam longint WK_HI = 134217727;
	localparam longint WK_LO = -134217728;
	localparam longint MAG_HI = 67108863;

	typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [3:0] cfg;
		item_t      it;
		bit         typed;
		result_t    res;
	} row_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;
	logic    cfg_valid;
	logic    cfg_ready;
	logic [3:0] cfg_data;

	// spectrum predictor state
	longint    tw_re [TW_HALF];
	longint    tw_im [TW_HALF];
	longint    work_re [MAX_PTS];
	longint    work_im [MAX_PTS];
	longint    mag_tab [MAX_PTS];
	logic [3:0] size_reg;
	int        load_cnt;
	bit        frame_ok;

	result_t   pending_mags[$];
	int        mismatches;
	int        sent;
	bit        no_idle;
	int        stall_left;
	row_t      dir_rows[$];

	fft_magnitude_spectrum dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Q31 cos and sin of a first-octant angle
	function automatic void octant_q31(input longint unsigned m, output longint c,
			output longint s);
		longint unsigned x;
		longint unsigned t;
		x = ((TWO_PI / 64'(MAX_PTS)) * m + (64'd1 << 28)) >> 29;
		t = x;
		c = 64'sd1 <<< 31;
		s = longint'(x);
		for (int n = 2; n <= 15; n++) begin
			t = ((t * x) >> 31) / 64'(n);
			case (n % 4)
				0: c = c + longint'(t);
				1: s = s + longint'(t);
				2: c = c - longint'(t);
				default: s = s - longint'(t);
			endcase
		end
	endfunction

	function automatic longint q31_to_tw(input longint q);
		longint v;
		longint hi;
		hi = (64'sd1 <<< (TW_W - 1)) - 1;
		v = (q + (64'sd1 <<< (31 - TW_W))) >>> (32 - TW_W);
		if (v > hi) v = hi;
		if (v < -hi - 1) v = -hi - 1;
		return v;
	endfunction

	function automatic void make_twiddles();
		longint unsigned m;
		longint c;
		longint s;
		bit neg;
		for (int j = 0; j < TW_HALF; j++) begin
			m = longint'(j);
			neg = 0;
			if (j > MAX_PTS / 4) begin
				m = longint'(TW_HALF - j);
				neg = 1;
			end
			if (m <= MAX_PTS / 8) octant_q31(m, c, s);
			else octant_q31(MAX_PTS / 4 - m, s, c);
			if (neg) c = -c;
			tw_re[j] = q31_to_tw(c);
			tw_im[j] = q31_to_tw(-s);
		end
	endfunction

	function automatic longint sat_wk(input longint v);
		return v < WK_LO ? WK_LO : (v > WK_HI ? WK_HI : v);
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic int eff_log2();
		int l;
		l = int'(size_reg);
		if (l < 1) l = 1;
		if (l > MAX_LOG2) l = MAX_LOG2;
		return l;
	endfunction

	function automatic void run_fft(input int bits);
		int npts;
		int r;
		int v;
		int stp;
		int ia;
		int ib;
		longint tr;
		longint pr;
		longint pim;
		longint er;
		longint ei;
		longint unsigned m;
		npts = 1 << bits;
		for (int i = 1; i < npts; i++) begin
			r = 0;
			v = i;
			for (int b = 0; b < bits; b++) begin
				r = (r << 1) | (v & 1);
				v = v >> 1;
			end
			if (r > i) begin
				tr = work_re[i]; work_re[i] = work_re[r]; work_re[r] = tr;
				tr = work_im[i]; work_im[i] = work_im[r]; work_im[r] = tr;
			end
		end
		for (int len = 2; len <= npts; len = len << 1) begin
			stp = MAX_PTS / len;
			for (int i = 0; i < npts; i += len) begin
				for (int k = 0; k < len / 2; k++) begin
					ia = i + k;
					ib = i + k + len / 2;
					pr = (tw_re[k*stp] * work_re[ib] - tw_im[k*stp] * work_im[ib]
						+ (64'sd1 <<< (TW_W - 2))) >>> (TW_W - 1);
					pim = (tw_re[k*stp] * work_im[ib] + tw_im[k*stp] * work_re[ib]
						+ (64'sd1 <<< (TW_W - 2))) >>> (TW_W - 1);
					er = work_re[ia];
					ei = work_im[ia];
					work_re[ia] = sat_wk(er + pr);
					work_im[ia] = sat_wk(ei + pim);
					work_re[ib] = sat_wk(er - pr);
					work_im[ib] = sat_wk(ei - pim);
				end
			end
		end
		for (int i = 0; i < npts; i++) begin
			m = root_floor(longint'(work_re[i] * work_re[i])
				+ longint'(work_im[i] * work_im[i]));
			mag_tab[i] = m > MAG_HI ? MAG_HI : longint'(m);
		end
	endfunction

	// advance the predictor by one accepted item; returns 1 with a result on a read
	function automatic bit predict_item(input item_t it, output result_t res);
		int bits;
		int npts;
		bits = eff_log2();
		npts = 1 << bits;
		res = '0;
		if (it.action == ACT_LOAD) begin
			if (load_cnt >= npts) load_cnt = 0;
			work_re[load_cnt] = longint'(it.sample);
			work_im[load_cnt] = 0;
			load_cnt++;
			if (load_cnt >= npts) begin
				run_fft(bits);
				load_cnt = 0;
				frame_ok = 1;
			end
			return 0;
		end
		if (frame_ok && int'(it.bin_index) < npts) begin
			res.magnitude = mag_tab[it.bin_index][MAG_W-1:0];
			res.spectrum_valid = 1'b1;
		end
		return 1;
	endfunction

	// result side: compare and drive stall bursts
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_mags.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result mag=%0d valid=%0b",
						result.magnitude, result.spectrum_valid);
			end else begin
				want = pending_mags.pop_front();
				if (result.magnitude !== want.magnitude
						|| result.spectrum_valid !== want.spectrum_valid) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected mag=%0d valid=%0b, got mag=%0d valid=%0b",
							want.magnitude, want.spectrum_valid,
							result.magnitude, result.spectrum_valid);
				end
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_stall <= 1'b1;
		end else if (!no_idle && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 18);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
		result_t res;
		// drop idling over the last stretch of the run
		if (sent > TOTAL_ITEMS - 250) no_idle = 1;
		if (!no_idle && $urandom_range(0, 7) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		if (predict_item(it, res))
			pending_mags.push_back(typed ? typed_res : res);
		sent++;
	endtask

	task automatic write_size(input logic [3:0] val);
		int lg;
		item_valid <= 1'b0;
		while (pending_mags.size() != 0) @(posedge clk);
		// a frame may still be in the transform after its last load
		lg = eff_log2();
		repeat (5 * ((1 << lg) / 2) * lg + 32 * (1 << lg) + 64) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		size_reg = val;
		load_cnt = 0;
		frame_ok = 0;
	endtask

	function automatic item_t load_of(input logic signed [SMP_W-1:0] s);
		item_t it;
		it = '0;
		it.action = ACT_LOAD;
		it.sample = s;
		it.bin_index = MAX_LOG2'($urandom);
		return it;
	endfunction

	function automatic item_t read_of(input logic [MAX_LOG2-1:0] b);
		item_t it;
		it = '0;
		it.action = ACT_READ;
		it.sample = SMP_W'($urandom);
		it.bin_index = b;
		return it;
	endfunction

	function automatic logic signed [SMP_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return SMP_W'($signed($urandom_range(0, 15)) - 8);
			default: return SMP_W'($urandom);
		endcase
	endfunction

	function automatic void add_row(input row_kind_t k, input logic [3:0] c, input item_t it,
			input bit typed);
		row_t r;
		r.kind = k;
		r.cfg = c;
		r.it = it;
		r.typed = typed;
		r.res = '0;
		dir_rows.push_back(r);
	endfunction

	initial begin
		int lg;
		int npts;
		int frames;
		logic [3:0] sz;
		item_t none;
		none = '0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mismatches = 0;
		sent = 0;
		no_idle = 0;
		stall_left = 0;
		size_reg = 4'd10;
		load_cnt = 0;
		frame_ok = 0;
		make_twiddles();

		// typed rows expect magnitude 0, flag 0 (no frame yet or bin out of range)
		add_row(ROW_ITEM, 4'd0, read_of(10'd0), 1);
		add_row(ROW_ITEM, 4'd0, read_of(10'd1023), 1);
		add_row(ROW_ITEM, 4'd0, load_of(16'sh7FFF), 0);
		add_row(ROW_ITEM, 4'd0, read_of(10'd5), 1);
		add_row(ROW_CFG, 4'd1, none, 0);
		add_row(ROW_ITEM, 4'd0, read_of(10'd0), 1);
		add_row(ROW_ITEM, 4'd0, load_of(16'sh7FFF), 0);
		add_row(ROW_ITEM, 4'd0, load_of(16'sh8000), 0);
		add_row(ROW_ITEM, 4'd0, read_of(10'd0), 0);
		add_row(ROW_ITEM, 4'd0, read_of(10'd1), 0);
		add_row(ROW_ITEM, 4'd0, read_of(10'd2), 1);
		add_row(ROW_ITEM, 4'd0, read_of(10'd1023), 1);
		add_row(ROW_CFG, 4'd0, none, 0);
		add_row(ROW_ITEM, 4'd0, load_of(16'sh8000), 0);
		add_row(ROW_ITEM, 4'd0, load_of(16'sh8000), 0);
		add_row(ROW_ITEM, 4'd0, read_of(10'd0), 0);
		add_row(ROW_ITEM, 4'd0, read_of(10'd1), 0);
		add_row(ROW_ITEM, 4'd0, read_of(10'd2), 1);
		add_row(ROW_CFG, 4'd2, none, 0);
		add_row(ROW_ITEM, 4'd0, load_of(16'sh7FFF), 0);
		add_row(ROW_ITEM, 4'd0, load_of(16'sh8000), 0);
		add_row(ROW_ITEM, 4'd0, load_of(16'sh0000), 0);
		add_row(ROW_ITEM, 4'd0, load_of(16'shFFFF), 0);
		for (int b = 0; b < 4; b++) add_row(ROW_ITEM, 4'd0, read_of(MAX_LOG2'(b)), 0);
		add_row(ROW_ITEM, 4'd0, read_of(10'd4), 1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) write_size(dir_rows[i].cfg);
			else send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
		end

		// first phase takes the largest setting, clamped to full length
		sz = 4'd15;
		while (sent < TOTAL_ITEMS) begin
			write_size(sz);
			lg = eff_log2();
			npts = 1 << lg;
			frames = lg >= 8 ? 1 : $urandom_range(1, 3);
			for (int f = 0; f < frames && sent < TOTAL_ITEMS; f++) begin
				for (int s = 0; s < npts && sent < TOTAL_ITEMS; s++) begin
					if ($urandom_range(0, 4) == 0)
						send_item(read_of(MAX_LOG2'($urandom_range(0, 1)
							? $urandom_range(0, npts - 1) : $urandom)), 0, '0);
					send_item(load_of(rand_sample()), 0, '0);
				end
				repeat ($urandom_range(2, 8))
					send_item(read_of(MAX_LOG2'($urandom_range(0, 5) == 0 ? $urandom
						: $urandom_range(0, npts - 1))), 0, '0);
			end
			// a partial frame keeps the previous spectrum readable
			if ($urandom_range(0, 2) == 0 && npts > 2) begin
				send_item(load_of(rand_sample()), 0, '0);
				send_item(read_of(MAX_LOG2'($urandom_range(0, npts - 1))), 0, '0);
			end
			sz = $urandom_range(0, 5) == 0 ? 4'($urandom_range(7, 9))
				: 4'($urandom_range(0, 6));
			// at times, hold off until the block has returned every pending result
			if ($urandom_range(0, 3) == 0) begin
				item_valid <= 1'b0;
				while (pending_mags.size() != 0) @(posedge clk);
			end
		end
		item_valid <= 1'b0;
		while (pending_mags.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending_mags.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

/* fft_magnitude_spectrum.f */
sv/fms_pkg.sv
sv/fms_front.sv
sv/fms_back.sv
sv/fft_magnitude_spectrum.sv
bench/tb_fft_magnitude_spectrum.sv
